@@ rtl/pfc_pkg.sv @@
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types, register indexes and helpers for the pixel format converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pfc_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_DEPTH_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_LAYOUT        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_CHANNEL_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_LAYOUT        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_CHANNEL_COUNT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_EXT_ALPHA     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_DIMS          = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_DIMS          = 3'd7;

    localparam logic [2:0] DEPTH_1BPP  = 3'd0;
    localparam logic [2:0] DEPTH_8BPP  = 3'd1;
    localparam logic [2:0] DEPTH_16BPP = 3'd2;
    localparam logic [2:0] DEPTH_24BPP = 3'd3;
    localparam logic [2:0] DEPTH_32BPP = 3'd4;

    localparam logic [2:0] CH_R = 3'd0;
    localparam logic [2:0] CH_G = 3'd1;
    localparam logic [2:0] CH_B = 3'd2;
    localparam logic [2:0] CH_A = 3'd3;

    localparam logic [15:0] MASK_565_R = 16'hF800;
    localparam logic [15:0] MASK_565_G = 16'h07E0;
    localparam logic [15:0] MASK_565_B = 16'h001F;
    localparam logic [7:0]  FULL_BYTE  = 8'd255;

    localparam logic [2:0]  RST_DEPTH_MODE = DEPTH_24BPP;
    localparam logic [11:0] RST_LAYOUT     = 12'd2328;
    localparam logic [2:0]  RST_COUNT      = 3'd3;

    typedef struct packed {
        logic [31:0] raw_pixel;
        logic [7:0]  ext_alpha;
    } pfc_in_t;

    typedef struct packed {
        logic [31:0] out_bytes;
        logic [2:0]  out_count;
        logic        frame_last;
    } pfc_out_t;

    typedef struct packed {
        logic [2:0]  src_depth_mode;
        logic [11:0] src_layout;
        logic [2:0]  src_channel_count;
        logic [11:0] dst_layout;
        logic [2:0]  dst_channel_count;
        logic        use_ext_alpha;
        logic [31:0] src_dims;
        logic [31:0] dst_dims;
    } pfc_cfg_t;

    typedef struct packed {
        logic [31:0] raw_pixel;
        logic [7:0]  ext_alpha;
        logic        pad;
        logic        frame_start;
        logic        frame_last;
        logic [2:0]  bit_idx;
    } pfc_item_t;

    function automatic logic [2:0] clamp_count(input logic [2:0] c);
        logic [2:0] r;
        if (c == 3'd0)
        begin
            r = 3'd1;
        end
        else if (c > 3'd4)
        begin
            r = 3'd4;
        end
        else
        begin
            r = c;
        end
        return r;
    endfunction

    function automatic logic [2:0] slot_code(input logic [11:0] layout, input logic [1:0] n);
        return layout[3*n +: 3];
    endfunction

endpackage

`default_nettype wire

@@ rtl/pixel_format_converter_core.sv @@
// ----------------------------------------------------------------------------
// pixel_format_converter_core
// Converts one target pixel position per transaction into target channel
// bytes, decoding 1/8/16/24/32 bpp sources with alpha fill and padding.
//
//   channel  handshake            payload
//   in       in_valid/in_ready    in_data  (raw_pixel, ext_alpha)
//   out      out_valid/out_ready  out_data (out_bytes, out_count, frame_last)
//   cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one transaction per cycle sustained while the output is not stalled; an
// accepted input is registered in a queue entry, then in the output register,
// before it is offered on out_valid
// the two-entry queue and the output register hold three transactions while
// output is stalled, then in_ready drops; in_ready never depends on out_ready
// reset clears counters, channel registers and config to defaults
// cfg_ready is always high
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pixel_format_converter_core
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire pfc_pkg::pfc_in_t                   in_data,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output pfc_pkg::pfc_out_t                       out_data,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [pfc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [31:0]                        cfg_data
);

    pfc_pkg::pfc_cfg_t  cfg_reg;
    logic               push_valid;
    logic               push_ready;
    pfc_pkg::pfc_item_t push_item;
    logic               pop_valid;
    logic               pop_ready;
    pfc_pkg::pfc_item_t pop_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.src_depth_mode    <= pfc_pkg::RST_DEPTH_MODE;
            cfg_reg.src_layout        <= pfc_pkg::RST_LAYOUT;
            cfg_reg.src_channel_count <= pfc_pkg::RST_COUNT;
            cfg_reg.dst_layout        <= pfc_pkg::RST_LAYOUT;
            cfg_reg.dst_channel_count <= pfc_pkg::RST_COUNT;
            cfg_reg.use_ext_alpha     <= 1'b0;
            cfg_reg.src_dims          <= 32'd0;
            cfg_reg.dst_dims          <= 32'd0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                pfc_pkg::CFG_SRC_DEPTH_MODE:    cfg_reg.src_depth_mode    <= cfg_data[2:0];
                pfc_pkg::CFG_SRC_LAYOUT:        cfg_reg.src_layout        <= cfg_data[11:0];
                pfc_pkg::CFG_SRC_CHANNEL_COUNT: cfg_reg.src_channel_count <= cfg_data[2:0];
                pfc_pkg::CFG_DST_LAYOUT:        cfg_reg.dst_layout        <= cfg_data[11:0];
                pfc_pkg::CFG_DST_CHANNEL_COUNT: cfg_reg.dst_channel_count <= cfg_data[2:0];
                pfc_pkg::CFG_USE_EXT_ALPHA:     cfg_reg.use_ext_alpha     <= cfg_data[0];
                pfc_pkg::CFG_SRC_DIMS:          cfg_reg.src_dims          <= cfg_data;
                pfc_pkg::CFG_DST_DIMS:          cfg_reg.dst_dims          <= cfg_data;
                default:                        cfg_reg.dst_dims          <= cfg_data;
            endcase
        end
    end

    pfc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    pfc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    pfc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

@@ rtl/pfc_front.sv @@
// ----------------------------------------------------------------------------
// pfc_front
// Position tracking: classifies each transaction as source or padding and
// tags frame start, frame end and the 1 bpp bit index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfc_front
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pfc_pkg::pfc_cfg_t  cfg,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire pfc_pkg::pfc_in_t   in_data,
    output logic                    push_valid,
    input  wire logic               push_ready,
    output pfc_pkg::pfc_item_t      push_item
);

    localparam int CW = pfc_pkg::COORD_WIDTH;
    localparam int MW = (CW > 16) ? CW + 1 : 17;

    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [CW-1:0] row_reg;
    logic [CW-1:0] row_next;
    logic [15:0]   src_w;
    logic [15:0]   src_h;
    logic [15:0]   dst_w;
    logic [15:0]   dst_h;
    logic [CW:0]   col_inc;
    logic [CW:0]   row_inc;
    logic          col_end;
    logic          row_end;
    logic [2:0]    bit_pos;
    logic          accept;

    assign src_w = cfg.src_dims[15:0];
    assign src_h = cfg.src_dims[31:16];
    assign dst_w = (cfg.dst_dims[15:0] == 16'd0) ? 16'd1 : cfg.dst_dims[15:0];
    assign dst_h = (cfg.dst_dims[31:16] == 16'd0) ? 16'd1 : cfg.dst_dims[31:16];

    assign col_inc = {1'b0, col_reg} + (CW+1)'(1);
    assign row_inc = {1'b0, row_reg} + (CW+1)'(1);
    assign col_end = MW'(col_inc) >= MW'(dst_w);
    assign row_end = MW'(row_inc) >= MW'(dst_h);

    // low three bits of row * width + col
    assign bit_pos = 3'(row_reg[2:0] * src_w[2:0]) + col_reg[2:0];

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign accept     = in_valid && push_ready;

    always_comb
    begin
        push_item.raw_pixel   = in_data.raw_pixel;
        push_item.ext_alpha   = in_data.ext_alpha;
        push_item.pad         = !((MW'(col_reg) < MW'(src_w)) && (MW'(row_reg) < MW'(src_h)));
        push_item.frame_start = (col_reg == '0) && (row_reg == '0);
        push_item.frame_last  = col_end && row_end;
        push_item.bit_idx     = bit_pos;
    end

    always_comb
    begin
        if (col_end)
        begin
            col_next = '0;
            row_next = row_end ? '0 : row_inc[CW-1:0];
        end
        else
        begin
            col_next = col_inc[CW-1:0];
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/pfc_queue.sv @@
// ----------------------------------------------------------------------------
// pfc_queue
// Two-entry queue between the classifying front and the converting back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfc_queue
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push_valid,
    output logic                     push_ready,
    input  wire pfc_pkg::pfc_item_t  push_item,
    output logic                     pop_valid,
    input  wire logic                pop_ready,
    output pfc_pkg::pfc_item_t       pop_item
);

    pfc_pkg::pfc_item_t entry_reg [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         count_reg;
    logic [1:0]         count_next;
    logic               push;
    logic               pop;

    assign push_ready = count_reg != 2'd2;
    assign pop_valid  = count_reg != 2'd0;
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/pfc_back.sv @@
// ----------------------------------------------------------------------------
// pfc_back
// Decodes the source pixel into the channel registers, applies alpha fill and
// packs the target bytes into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfc_back
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire pfc_pkg::pfc_cfg_t   cfg,
    input  wire logic                pop_valid,
    output logic                     pop_ready,
    input  wire pfc_pkg::pfc_item_t  pop_item,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output pfc_pkg::pfc_out_t        out_data
);

    logic [7:0]        chan_reg  [4];
    logic [7:0]        chan_next [4];
    logic              out_valid_reg;
    pfc_pkg::pfc_out_t out_reg;
    pfc_pkg::pfc_out_t out_next;
    logic [2:0]        scount;
    logic [2:0]        dcount;
    logic              has_alpha;
    logic [7:0]        b0;
    logic [15:0]       w565;
    logic [7:0]        grey;
    logic [2:0]        code;
    logic              pop;

    assign scount    = pfc_pkg::clamp_count(cfg.src_channel_count);
    assign dcount    = pfc_pkg::clamp_count(cfg.dst_channel_count);
    assign b0        = pop_item.raw_pixel[7:0];
    assign w565      = {b0, pop_item.raw_pixel[15:8]};
    assign pop_ready = !out_valid_reg || out_ready;
    assign pop       = pop_valid && pop_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        has_alpha = 1'b0;
        for (int n = 0; n < 4; n++)
        begin
            if ((3'(n) < scount) &&
                (pfc_pkg::slot_code(cfg.src_layout, 2'(n)) == pfc_pkg::CH_A))
            begin
                has_alpha = 1'b1;
            end
        end
    end

    always_comb
    begin
        grey = 8'd0;
        code = 3'd0;
        for (int c = 0; c < 4; c++)
        begin
            chan_next[c] = pop_item.frame_start ? 8'd0 : chan_reg[c];
        end
        if (!pop_item.pad)
        begin
            unique case (cfg.src_depth_mode)
                pfc_pkg::DEPTH_1BPP:
                begin
                    grey = b0[pop_item.bit_idx] ? pfc_pkg::FULL_BYTE : 8'd0;
                    chan_next[pfc_pkg::CH_R[1:0]] = grey;
                    chan_next[pfc_pkg::CH_G[1:0]] = grey;
                    chan_next[pfc_pkg::CH_B[1:0]] = grey;
                end
                pfc_pkg::DEPTH_8BPP:
                begin
                    grey = (b0 != 8'd0) ? pfc_pkg::FULL_BYTE : 8'd0;
                    chan_next[pfc_pkg::CH_R[1:0]] = grey;
                    chan_next[pfc_pkg::CH_G[1:0]] = grey;
                    chan_next[pfc_pkg::CH_B[1:0]] = grey;
                    chan_next[pfc_pkg::CH_A[1:0]] = b0;
                end
                pfc_pkg::DEPTH_16BPP:
                begin
                    code = pfc_pkg::slot_code(cfg.src_layout, 2'd0);
                    if (!code[2])
                    begin
                        chan_next[code[1:0]] = 8'((w565 & pfc_pkg::MASK_565_R) >> 11);
                    end
                    code = pfc_pkg::slot_code(cfg.src_layout, 2'd1);
                    if (!code[2])
                    begin
                        chan_next[code[1:0]] = 8'((w565 & pfc_pkg::MASK_565_G) >> 5);
                    end
                    code = pfc_pkg::slot_code(cfg.src_layout, 2'd2);
                    if (!code[2])
                    begin
                        chan_next[code[1:0]] = 8'(w565 & pfc_pkg::MASK_565_B);
                    end
                end
                pfc_pkg::DEPTH_24BPP, pfc_pkg::DEPTH_32BPP:
                begin
                    for (int n = 0; n < 4; n++)
                    begin
                        code = pfc_pkg::slot_code(cfg.src_layout, 2'(n));
                        if ((3'(n) < scount) && !code[2])
                        begin
                            chan_next[code[1:0]] = pop_item.raw_pixel[8*n +: 8];
                        end
                    end
                end
                default:
                begin
                    grey = 8'd0;
                end
            endcase
            if (!has_alpha)
            begin
                chan_next[pfc_pkg::CH_A[1:0]] =
                    cfg.use_ext_alpha ? pop_item.ext_alpha : pfc_pkg::FULL_BYTE;
            end
        end
    end

    always_comb
    begin
        out_next.out_bytes  = 32'd0;
        out_next.out_count  = dcount;
        out_next.frame_last = pop_item.frame_last;
        for (int n = 0; n < 4; n++)
        begin
            if (!pop_item.pad && (3'(n) < dcount) &&
                !cfg.dst_layout[3*n + 2])
            begin
                out_next.out_bytes[8*n +: 8] = chan_next[cfg.dst_layout[3*n +: 2]];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int c = 0; c < 4; c++)
            begin
                chan_reg[c] <= 8'd0;
            end
        end
        else
        begin
            if (pop)
            begin
                out_valid_reg <= 1'b1;
                for (int c = 0; c < 4; c++)
                begin
                    chan_reg[c] <= chan_next[c];
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/pfc_checker.sv @@
// ----------------------------------------------------------------------------
// pfc_checker
// Port-level checks on the pixel format converter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfc_checker
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    input  wire logic                               in_ready,
    input  wire pfc_pkg::pfc_in_t                   in_data,
    input  wire logic                               out_valid,
    input  wire logic                               out_ready,
    input  wire pfc_pkg::pfc_out_t                  out_data
);

    // waiting input transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("input transaction changed while waiting");

    // stalled output transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output transaction changed while stalled");

    // byte count in range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.out_count == 3'd1) || (out_data.out_count == 3'd2) ||
                      (out_data.out_count == 3'd3) || (out_data.out_count == 3'd4))
        else $error("out_count out of range");

    // unused bytes are zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_data.out_count != 3'd1) || (out_data.out_bytes[31:8] == 24'd0)) &&
                      ((out_data.out_count != 3'd2) || (out_data.out_bytes[31:16] == 16'd0)) &&
                      ((out_data.out_count != 3'd3) || (out_data.out_bytes[31:24] == 8'd0)))
        else $error("bytes beyond out_count not zero");

    // no output straight out of reset
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("output valid straight out of reset");

endmodule

bind pixel_format_converter_core pfc_checker u_pfc_checker (.*);

`default_nettype wire
